// ===== rtl/vtq_pkg.sv =====
// shared types and constants of the virtual timer queue
`timescale 1ns / 1ps
`default_nettype none

package vtq_pkg;

    // fixed field widths
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 8;

    // default table size and per-tick report limit
    localparam int unsigned SLOTS_DEF   = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    // operation codes carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    // one memory word per slot
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] runs;
        logic [TIME_W-1:0] deadline;
    } t_slot_word;

    // status of one scan pass
    typedef struct packed {
        logic found;
        logic more;
    } t_scan_stat;

endpackage

`default_nettype wire

// ===== rtl/vtq_slot_mem.sv =====
// slot table memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module vtq_slot_mem
    import vtq_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF,
    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_slot_word       i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_slot_word            o_rd_data
);

    t_slot_word r_mem [SLOTS];
    t_slot_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/vtq_min_scan.sv =====
// running minimum over the slot words streamed out of the table
`timescale 1ns / 1ps
`default_nettype none

module vtq_min_scan
    import vtq_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF,
    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic              i_vld,
    input  wire logic              i_live,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire t_slot_word        i_word,
    input  wire logic [TIME_W-1:0] i_now,
    output t_scan_stat             o_stat,
    output logic [IDX_W-1:0]       o_best_idx,
    output t_slot_word             o_best_word
);

    logic             r_found;
    logic             r_more;
    logic             n_found;
    logic             n_more;
    logic [IDX_W-1:0] r_best_idx;
    t_slot_word       r_best_word;
    logic             due;
    logic             take;

    // slot is due and beats the current best; ascending order keeps lower slot on ties
    assign due  = i_vld && i_live && (i_word.deadline <= i_now);
    assign take = due && (!r_found || (i_word.deadline < r_best_word.deadline));

    // found and more flags
    always_comb begin
        n_found = r_found;
        n_more  = r_more;
        if (i_clear) begin
            n_found = 1'b0;
            n_more  = 1'b0;
        end else if (due) begin
            n_found = 1'b1;
            n_more  = r_more | r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_found <= n_found;
            r_more  <= n_more;
        end
    end

    // best candidate payload
    always_ff @(posedge i_clk) begin
        if (!i_clear && take) begin
            r_best_idx  <= i_idx;
            r_best_word <= i_word;
        end
    end

    assign o_stat.found = r_found;
    assign o_stat.more  = r_more;
    assign o_best_idx   = r_best_idx;
    assign o_best_word  = r_best_word;

endmodule

`default_nettype wire

// ===== rtl/virtual_timer_queue.sv =====
// virtual timer queue top level: request handling, scan sequencer, output register
`timescale 1ns / 1ps
`default_nettype none

// Timer table of SLOTS slots kept in one memory word per slot (deadline, period,
// runs left) with armed bits in flip-flops. An arm request writes its slot and
// the block stays ready for the next request. A tick request bumps the tick
// count and then runs scan passes: each pass reads every slot through the single
// memory read port, one slot a cycle, and picks the earliest due slot. Each pass
// that finds a due slot reports it and writes it back (retire, reload, or
// decrement and reload), and also tells whether another due slot is left, so a
// tick runs one pass per reported slot and a tick with nothing due runs one pass
// that reports nothing. At most 16 reports are made per tick.
// Results wait in an output register; a pass waits for it only when a report is
// ready and the previous one has not been taken.
module virtual_timer_queue
    import vtq_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // slave side
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // slot[3:0], period[35:4], runs[67:36]
    input  wire logic                   s_axis_tuser,  // operation[0]
    // master side
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // expired_slot[3:0]
    output logic                        m_axis_tlast   // last_of_run
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] n_now;
    logic [SLOTS-1:0]  r_armed;
    logic [SLOTS-1:0]  n_armed;
    logic [SLOTS-1:0]  r_done;
    logic [SLOTS-1:0]  n_done;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  n_addr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_last;

    logic              in_acc;
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_period;
    logic [TIME_W-1:0] in_runs;
    logic              arm_ok;
    logic [TIME_W-1:0] arm_period;
    logic              out_free;
    logic              decide_fire;
    logic              res_last;
    logic              rd_en;
    logic              scan_clear;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    t_slot_word        wr_data;
    t_slot_word        rd_data;
    t_scan_stat        stat;
    logic [IDX_W-1:0]  best_idx;
    t_slot_word        best_word;
    t_slot_word        reload_word;

    // request unpacking
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign in_slot    = s_axis_tdata[SLOT_W-1:0];
    assign in_period  = s_axis_tdata[SLOT_W +: TIME_W];
    assign in_runs    = s_axis_tdata[SLOT_W+TIME_W +: TIME_W];
    assign arm_ok     = in_acc && (s_axis_tuser == OP_ARM) && (32'(in_slot) < 32'(SLOTS));
    assign arm_period = (in_period == '0) ? TIME_W'(1) : in_period;

    assign s_axis_tready = (r_state == ST_IDLE);

    // report handoff
    assign out_free    = !r_out_valid || m_axis_tready;
    assign decide_fire = (r_state == ST_DECIDE) && stat.found && out_free;
    assign res_last    = !stat.more || (r_count == CNT_W'(MAX_RESULTS - 1));

    // reloaded word for the reported slot
    always_comb begin
        reload_word          = best_word;
        reload_word.deadline = r_now + best_word.period;
        if (best_word.runs != '0) begin
            reload_word.runs = best_word.runs - TIME_W'(1);
        end
    end

    // memory write port: arm in idle, write-back after a pass
    always_comb begin
        we      = arm_ok || decide_fire;
        wr_addr = best_idx;
        wr_data = reload_word;
        if (arm_ok) begin
            wr_addr          = IDX_W'(in_slot);
            wr_data.period   = arm_period;
            wr_data.runs     = in_runs;
            wr_data.deadline = r_now + arm_period;
        end
    end

    assign rd_en = (r_state == ST_SCAN);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_armed     = r_armed;
        n_done      = r_done;
        n_addr      = r_addr;
        n_count     = r_count;
        n_out_valid = r_out_valid && !m_axis_tready;
        scan_clear  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (arm_ok) begin
                    n_armed[IDX_W'(in_slot)] = 1'b1;
                end else if (in_acc && (s_axis_tuser == OP_TICK)) begin
                    n_now      = r_now + TIME_W'(1);
                    n_done     = '0;
                    n_count    = '0;
                    n_addr     = '0;
                    scan_clear = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + IDX_W'(1);
                if (r_addr == IDX_W'(SLOTS - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!stat.found) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_done[best_idx] = 1'b1;
                    if (best_word.runs == TIME_W'(1)) begin
                        n_armed[best_idx] = 1'b0;
                    end
                    n_count = r_count + CNT_W'(1);
                    if (res_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_addr     = '0;
                        scan_clear = 1'b1;
                        n_state    = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_armed     <= '0;
            r_done      <= '0;
            r_addr      <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_armed     <= n_armed;
            r_done      <= n_done;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_rd_vld    <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    // read index tracks the memory latency; report payload
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (decide_fire) begin
            r_out_slot <= SLOT_W'(best_idx);
            r_out_last <= res_last;
        end
    end

    vtq_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    vtq_min_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (scan_clear),
        .i_vld       (r_rd_vld),
        .i_live      (r_armed[r_rd_idx] && !r_done[r_rd_idx]),
        .i_idx       (r_rd_idx),
        .i_word      (rd_data),
        .i_now       (r_now),
        .o_stat      (stat),
        .o_best_idx  (best_idx),
        .o_best_word (best_word)
    );

    // output ports
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_slot);
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench of the virtual timer queue against a timer table predictor
`timescale 1ns / 1ps

module testbench;
    import vtq_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 74;
    localparam int unsigned PAD_W       = IN_TDATA_W - SLOT_W - 2 * TIME_W;

    // one expected expiry report
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_expiry;

    // timer table predictor and store of pending expiry reports
    class expiry_board;
        logic [TIME_W-1:0] now_count;
        logic              armed     [SLOTS_DEF];
        logic [TIME_W-1:0] deadline  [SLOTS_DEF];
        logic [TIME_W-1:0] reload    [SLOTS_DEF];
        logic [TIME_W-1:0] runs_left [SLOTS_DEF];
        t_expiry           due_expiries[$];
        int unsigned       errors;

        function new();
            now_count = '0;
            errors    = 0;
            foreach (armed[i]) begin
                armed[i]     = 1'b0;
                deadline[i]  = '0;
                reload[i]    = '0;
                runs_left[i] = '0;
            end
        endfunction

        // apply one accepted request and queue the reports it causes
        function void note_request(logic op, logic [SLOT_W-1:0] slot,
                                   logic [TIME_W-1:0] period, logic [TIME_W-1:0] runs);
            logic    done [SLOTS_DEF];
            int      best;
            int      count;
            t_expiry hit;
            if (op == OP_ARM) begin
                if (period == '0) period = 1;
                deadline[slot]  = now_count + period;
                reload[slot]    = period;
                runs_left[slot] = runs;
                armed[slot]     = 1'b1;
                return;
            end
            now_count = now_count + 1;
            foreach (done[i]) done[i] = 1'b0;
            // earliest due slot first, lower slot wins a tie, each slot once per tick
            for (count = 0; count < MAX_RESULTS; count++) begin
                best = -1;
                for (int s = 0; s < SLOTS_DEF; s++) begin
                    if (armed[s] && !done[s] && deadline[s] <= now_count) begin
                        if (best < 0 || deadline[s] < deadline[best]) best = s;
                    end
                end
                if (best < 0) break;
                done[best] = 1'b1;
                hit.slot   = best[SLOT_W-1:0];
                hit.last   = 1'b0;
                due_expiries.push_back(hit);
                // retire, reload forever, or count down and reload
                if (runs_left[best] == 1) begin
                    armed[best] = 1'b0;
                end else begin
                    if (runs_left[best] != 0) runs_left[best] = runs_left[best] - 1;
                    deadline[best] = now_count + reload[best];
                end
            end
            // mark the final report of this tick
            if (count > 0) begin
                hit      = due_expiries.pop_back();
                hit.last = 1'b1;
                due_expiries.push_back(hit);
            end
        endfunction

        // compare one accepted report with the oldest pending one
        function void check_expiry(logic [SLOT_W-1:0] slot, logic last);
            t_expiry want;
            if (due_expiries.size() == 0) begin
                $error("unexpected expiry report: expired_slot %0d, last_of_run %0d", slot, last);
                errors++;
                return;
            end
            want = due_expiries.pop_front();
            if (slot !== want.slot) begin
                $error("expired_slot: expected %0d, got %0d", want.slot, slot);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // slot[3:0], period[35:4], runs[67:36]
    logic                   s_axis_tuser  = OP_TICK;  // operation[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // expired_slot[3:0]
    logic                   m_axis_tlast;

    expiry_board board;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned idle_plan  [4] = '{0, 47, 0, 9};
    int unsigned stall_plan [4] = '{0, 0, 47, 9};

    virtual_timer_queue #(
        .SLOTS(SLOTS_DEF)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // check reports and feed accepted requests to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_expiry(m_axis_tdata[SLOT_W-1:0], m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_request(s_axis_tuser, s_axis_tdata[SLOT_W-1:0],
                                   s_axis_tdata[SLOT_W +: TIME_W],
                                   s_axis_tdata[SLOT_W+TIME_W +: TIME_W]);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** virtual_timer_queue: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // drive one request and hold it until accepted
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                                input logic [TIME_W-1:0] period,
                                input logic [TIME_W-1:0] runs);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{PAD_W{1'b0}}, runs, period, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // tick with random content in the unused fields
    task automatic send_tick;
        send_request(OP_TICK, SLOT_W'($urandom), $urandom, $urandom);
    endtask

    // random arm or tick, mostly short periods so timers fire often
    task automatic send_random;
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] runs;
        int unsigned       pick;
        op   = ($urandom_range(99) < 40) ? OP_ARM : OP_TICK;
        slot = SLOT_W'($urandom_range(SLOTS_DEF - 1));
        pick = $urandom_range(99);
        if (pick < 70) period = $urandom_range(6);
        else if (pick < 85) period = $urandom_range(40, 7);
        else if (pick < 95) period = $urandom;
        else period = 32'hFFFF_FFFF - $urandom_range(3);
        pick = $urandom_range(99);
        if (pick < 40) runs = '0;
        else if (pick < 80) runs = $urandom_range(4, 1);
        else runs = $urandom;
        send_request(op, slot, period, runs);
    endtask

    // stop sending until every pending report has come
    task automatic wait_reports_drained;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.due_expiries.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tick with nothing armed
        send_tick;
        // zero period, tie on deadline, re-arm, wrapped deadline, extremes
        send_request(OP_ARM, 4'd0, 32'd0, 32'd1);
        send_request(OP_ARM, 4'd15, 32'd3, 32'd2);
        send_request(OP_ARM, 4'd5, 32'd3, 32'd0);
        send_request(OP_ARM, 4'd7, 32'd1, 32'hFFFF_FFFF);
        send_request(OP_ARM, 4'd7, 32'd2, 32'd3);
        send_request(OP_ARM, 4'd9, 32'hFFFF_FFFF, 32'd2);
        send_request(OP_ARM, 4'd12, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_ARM, 4'd3, 32'h7FFF_FFFF, 32'd0);
        repeat (6) send_tick;
        wait_reports_drained;

        // random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            repeat (PHASE_ITEMS) send_random;
            wait_reports_drained;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("** virtual_timer_queue: PASSED **");
        end else begin
            $display("** virtual_timer_queue: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vtq_pkg.sv
rtl/vtq_slot_mem.sv
rtl/vtq_min_scan.sv
rtl/virtual_timer_queue.sv
test/testbench.sv
